[hw/rtl/ase_pkg.sv]
// Package with shared types for the ascending sort engine.
`timescale 1ns / 1ps
package ase_pkg;

  localparam int unsigned ValueWidth = 32;

  typedef enum logic [1:0] {
    S_FILL,
    S_SETTLE,
    S_DRAIN
  } ase_state_e;

  typedef struct packed {
    logic                         vld;
    logic signed [ValueWidth-1:0] val;
  } ase_link_t;

  typedef struct packed {
    logic shift;
  } ase_ctrl_t;

endpackage

[hw/rtl/ase_cell.sv]
// One cell of the sorting chain: holds the smallest value it has seen, passes larger ones on.
`timescale 1ns / 1ps
module ase_cell import ase_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ase_ctrl_t ctrl_i,
  input  ase_link_t ins_i,
  input  ase_link_t right_i,
  output ase_link_t carry_o,
  output ase_link_t held_o
);

  ase_link_t held_q, held_d;
  ase_link_t carry_q, carry_d;

  always_comb begin
    held_d  = held_q;
    carry_d = carry_q;
    carry_d.vld = 1'b0;
    if (ctrl_i.shift) begin
      // Drain: take the right neighbor's value.
      held_d = right_i;
    end else if (ins_i.vld) begin
      if (!held_q.vld) begin
        held_d = ins_i;
      end else if (ins_i.val < held_q.val) begin
        held_d  = ins_i;
        carry_d = held_q;
      end else begin
        carry_d = ins_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      carry_q <= '0;
    end else begin
      held_q  <= held_d;
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;
  assign held_o  = held_q;

endmodule

[hw/rtl/ascending_sort_engine_core.sv]
// Top level of the ascending sort engine: insertion chain of cells and its sequencer.
`timescale 1ns / 1ps
// Usage:
//   Input channel: an item (sample_value_i, final_item_i) is taken at a rising
//   edge with start_i high and busy_o low. While a set is open, busy_o stays
//   low, so one item can enter every cycle.
//   An item with final_item_i set, or the item that brings the set to
//   MAX_ITEMS values, closes the set. busy_o then goes high.
//   After closing, the chain settles (values still in flight between
//   cells reach their place), then drains: one result per cycle,
//   result_valid_o high for exactly one cycle per value, ascending,
//   final_result_o set on the largest value. busy_o drops with that last
//   result, and the next set may start in the same cycle.
//   The first result follows the settle pass, registered from the head cell.
//   No new item is taken while a set settles or drains; the insertion wave
//   through the chain of MAX_ITEMS cells sets the settle length.
//   The receiver cannot stall; each result must be taken in its cycle.
//   Reset (rst_ni low, asynchronous) empties every cell and drops any open
//   set without results.
module ascending_sort_engine_core import ase_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [ValueWidth-1:0] sample_value_i,
  input  logic                         final_item_i,
  output logic                         result_valid_o,
  output logic signed [ValueWidth-1:0] sorted_value_o,
  output logic                         final_result_o
);

  localparam int unsigned CntWidth = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SetWidth = $clog2(MAX_ITEMS);

  ase_state_e state_q, state_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic [SetWidth-1:0] settle_q, settle_d;
  logic accept;
  logic closes;
  logic last_out;

  ase_ctrl_t ctrl;
  ase_link_t ins_link;
  ase_link_t carry [MAX_ITEMS];
  ase_link_t held  [MAX_ITEMS];

  logic                         out_vld_q, out_vld_d;
  logic signed [ValueWidth-1:0] out_val_q, out_val_d;
  logic                         out_fin_q, out_fin_d;

  assign accept = start_i && (state_q == S_FILL);
  // Close on the final marker or when this item fills the chain.
  assign closes = final_item_i || (count_q == CntWidth'(MAX_ITEMS - 1));
  // The head value is the last one when its neighbor is empty.
  assign last_out = !held[1].vld;

  assign ins_link.vld = accept;
  assign ins_link.val = sample_value_i;

  // Chain of cells; cell 0 is the smallest.
  for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
    ase_link_t ins_c;
    ase_link_t right_c;
    if (gi == 0) begin : g_head
      assign ins_c = ins_link;
    end else begin : g_body
      assign ins_c = carry[gi-1];
    end
    if (gi == MAX_ITEMS - 1) begin : g_tail
      assign right_c = '0;
    end else begin : g_mid
      assign right_c = held[gi+1];
    end
    ase_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .ins_i   (ins_c),
      .right_i (right_c),
      .carry_o (carry[gi]),
      .held_o  (held[gi])
    );
  end

  // Next state.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    settle_d = settle_q;
    unique case (state_q)
      S_FILL: begin
        if (accept) begin
          count_d = count_q + CntWidth'(1);
          if (closes) begin
            state_d  = S_SETTLE;
            settle_d = SetWidth'(MAX_ITEMS - 1);
          end
        end
      end
      S_SETTLE: begin
        if (settle_q == '0) begin
          state_d = S_DRAIN;
        end else begin
          settle_d = settle_q - SetWidth'(1);
        end
      end
      S_DRAIN: begin
        if (last_out) begin
          state_d = S_FILL;
          count_d = '0;
        end
      end
      default: begin
        state_d = S_FILL;
        count_d = '0;
      end
    endcase
  end

  // Outputs and chain control.
  always_comb begin
    ctrl.shift = 1'b0;
    out_vld_d  = 1'b0;
    out_val_d  = held[0].val;
    out_fin_d  = 1'b0;
    busy_o     = 1'b1;
    unique case (state_q)
      S_FILL: begin
        busy_o = 1'b0;
      end
      S_SETTLE: begin
        busy_o = 1'b1;
      end
      S_DRAIN: begin
        // Advance the chain one cell toward the head and present the head.
        ctrl.shift = 1'b1;
        out_vld_d  = 1'b1;
        out_fin_d  = last_out;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_FILL;
      count_q   <= '0;
      settle_q  <= '0;
      out_vld_q <= 1'b0;
      out_fin_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      settle_q  <= settle_d;
      out_vld_q <= out_vld_d;
      out_fin_q <= out_fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q <= out_val_d;
  end

  assign result_valid_o = out_vld_q;
  assign sorted_value_o = out_val_q;
  assign final_result_o = out_fin_q;

  // A result only follows a drain cycle.
  a_result_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_DRAIN))
    else $error("result outside drain");

  // The fill count never passes the chain length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(MAX_ITEMS))
    else $error("fill count overflow");

  // During drain the head cell always holds a value.
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> held[0].vld)
    else $error("empty head during drain");

  // No insertion is in flight once draining starts.
  a_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> !carry[0].vld)
    else $error("carry in flight during drain");

endmodule

[tb/sv/ascending_sort_engine_core_tb.sv]
// Self-checking testbench for ascending_sort_engine_core: sets of signed values in, sorted runs out.
`timescale 1ns / 1ps
module ascending_sort_engine_core_tb import ase_pkg::*; ();

  localparam int unsigned MaxItems      = 64;
  localparam int unsigned ItemTarget    = 360;
  // No handshake for this many cycles means the block is stuck. A settle
  // pass, which has no handshake, is a legal quiet stretch.
  localparam int unsigned WatchdogLimit = 2000;

  localparam logic signed [ValueWidth-1:0] ValMin = 32'h8000_0000;
  localparam logic signed [ValueWidth-1:0] ValMax = 32'h7fff_ffff;

  // How the values of one set are drawn.
  typedef enum int {
    VAL_WIDE,    // full 32-bit range
    VAL_NARROW,  // tiny range around zero, so duplicates are common
    VAL_EDGE     // mostly extremes, zero and +/-1
  } value_mode_e;

  typedef struct {
    logic signed [ValueWidth-1:0] value;
    logic                         last;
  } sorted_entry_t;

  // Collects the open set, sorts it when it closes and holds the run that
  // the block must give back.
  class sort_scoreboard;
    int unsigned                  capacity;
    int unsigned                  mismatches;
    logic signed [ValueWidth-1:0] open_set[$];
    sorted_entry_t                sorted_q[$];

    function new(int unsigned cap);
      capacity   = cap;
      mismatches = 0;
    endfunction

    function void note_item(logic signed [ValueWidth-1:0] value, logic last);
      logic signed [ValueWidth-1:0] key;
      sorted_entry_t                ent;
      int                           i;
      int                           j;
      open_set.push_back(value);
      if (!last && open_set.size() < capacity) return;
      for (i = 1; i < open_set.size(); i++) begin
        key = open_set[i];
        j = i;
        while (j > 0 && open_set[j-1] > key) begin
          open_set[j] = open_set[j-1];
          j--;
        end
        open_set[j] = key;
      end
      for (i = 0; i < open_set.size(); i++) begin
        ent.value = open_set[i];
        ent.last  = (i == open_set.size() - 1);
        sorted_q.push_back(ent);
      end
      open_set.delete();
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_result(logic signed [ValueWidth-1:0] value, logic last);
      sorted_entry_t want;
      if (sorted_q.size() == 0) begin
        report($sformatf("result %0d final %0b with nothing expected", value, last));
        return;
      end
      want = sorted_q.pop_front();
      if (value !== want.value)
        report($sformatf("sorted_value %0d, expected %0d", value, want.value));
      if (last !== want.last)
        report($sformatf("final_result %0b, expected %0b (value %0d)", last, want.last,
                         want.value));
    endtask

    function int unsigned pending();
      return sorted_q.size() + open_set.size();
    endfunction
  endclass

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         start_i        = 1'b0;
  logic signed [ValueWidth-1:0] sample_value_i = '0;
  logic                         final_item_i   = 1'b0;
  logic                         busy_o;
  logic                         result_valid_o;
  logic signed [ValueWidth-1:0] sorted_value_o;
  logic                         final_result_o;

  sort_scoreboard sorted_sb;
  int unsigned    quiet_cycles = 0;
  int unsigned    items_sent   = 0;

  always #2 clk_i = ~clk_i;

  ascending_sort_engine_core #(
    .MAX_ITEMS(MaxItems)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .sample_value_i (sample_value_i),
    .final_item_i   (final_item_i),
    .result_valid_o (result_valid_o),
    .sorted_value_o (sorted_value_o),
    .final_result_o (final_result_o)
  );

  // Check every strobed result at the edge that takes it. Outputs are read
  // before the block's own updates at that edge land, so there is no race.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sorted_sb.check_result(sorted_value_o, final_result_o);
    end
  end

  // Watchdog: restart on any handshake, give up after a long quiet stretch.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("ascending_sort_engine_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item after an idle gap and hold it until the block takes it.
  // With a zero gap start stays high, so back-to-back items see no bubble.
  task send_item(logic signed [ValueWidth-1:0] value, logic last, int unsigned gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    sample_value_i <= value;
    final_item_i   <= last;
    do @(posedge clk_i); while (busy_o);
    sorted_sb.note_item(sample_value_i, final_item_i);
    items_sent++;
  endtask

  function automatic logic signed [ValueWidth-1:0] draw_value(value_mode_e mode);
    case (mode)
      VAL_NARROW: return int'($urandom_range(0, 7)) - 4;
      VAL_EDGE: begin
        case ($urandom_range(0, 5))
          0: return ValMin;
          1: return ValMax;
          2: return '0;
          3: return -1;
          4: return 1;
          default: return $urandom();
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Send one set of the given size. A full set closes on its own, so its
  // final flag is random; shorter sets close on the flag of the last item.
  task send_set(int unsigned size, value_mode_e mode, logic burst);
    int unsigned k;
    logic        last;
    for (k = 0; k < size; k++) begin
      if (k != size - 1) last = 1'b0;
      else if (size == MaxItems) last = 1'($urandom_range(0, 1));
      else last = 1'b1;
      send_item(draw_value(mode), last, burst ? 0 : $urandom_range(0, 13));
    end
  endtask

  initial begin
    logic signed [ValueWidth-1:0] mixed_set[8];
    int unsigned                  k;
    sorted_sb = new(MaxItems);
    mixed_set = '{32'sd0, ValMax, ValMin, -32'sd1, 32'sd1, ValMax, ValMin, 32'sd0};

    // Hold reset low from time zero, then release it on an edge.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-value sets at both extremes.
    send_item(ValMin, 1'b1, 0);
    send_item(ValMax, 1'b1, 3);
    // Two values given in descending order.
    send_item(ValMax, 1'b0, 0);
    send_item(ValMin, 1'b1, 0);
    // Extremes, zero, +/-1 and duplicates in one set, no gaps.
    for (k = 0; k < 8; k++) begin
      send_item(mixed_set[k], k == 7, 0);
    end
    // All-equal set with gaps.
    for (k = 0; k < 4; k++) begin
      send_item(-32'sd7, k == 3, $urandom_range(0, 13));
    end

    // Random sets: mostly short, now and then a full store that closes itself.
    while (items_sent < ItemTarget) begin
      send_set(($urandom_range(0, 9) == 0) ? MaxItems : $urandom_range(1, 12),
               value_mode_e'($urandom_range(0, 2)), $urandom_range(0, 3) == 0);
    end
    start_i <= 1'b0;

    // Drain: wait for the last run, then let the block settle.
    while (sorted_sb.pending() != 0) @(posedge clk_i);
    repeat (2 * MaxItems) @(posedge clk_i);

    if (sorted_sb.mismatches == 0 && sorted_sb.pending() == 0) begin
      $display("ascending_sort_engine_core verification clean");
    end else begin
      $display("ascending_sort_engine_core verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ase_pkg.sv
hw/rtl/ase_cell.sv
hw/rtl/ascending_sort_engine_core.sv
tb/sv/ascending_sort_engine_core_tb.sv
